// ===== rtl/core/rrtt_pkg.sv =====
`timescale 1ns / 1ps
// rrtt_pkg: types, sizes and codes shared by the round-robin thread table
// depends on nothing; imported by rrtt_slot_ram and round_robin_thread_table
package rrtt_pkg;

    localparam int SLOTS      = 8;
    localparam int ID_BITS    = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int JOIN_BITS  = $clog2(SLOTS + 1);
    localparam int CNT_BITS   = $clog2(SLOTS + 1);

    typedef logic [SLOT_BITS-1:0]  slot_idx_t;
    typedef logic [ID_BITS-1:0]    thread_id_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [JOIN_BITS-1:0]  joiner_t;
    typedef logic [CNT_BITS-1:0]   scan_cnt_t;
    typedef logic [2:0]            slot_state_t;
    typedef logic [1:0]            opcode_t;
    typedef logic [1:0]            status_t;

    localparam slot_state_t ST_UNUSED   = 3'd0;
    localparam slot_state_t ST_RUNNABLE = 3'd1;
    localparam slot_state_t ST_RUNNING  = 3'd2;
    localparam slot_state_t ST_SLEEPING = 3'd3;
    localparam slot_state_t ST_ZOMBIE   = 3'd4;

    localparam opcode_t OP_CREATE = 2'd0;
    localparam opcode_t OP_EXIT   = 2'd1;
    localparam opcode_t OP_JOIN   = 2'd2;
    localparam opcode_t OP_YIELD  = 2'd3;

    localparam status_t STATUS_DONE    = 2'd0;
    localparam status_t STATUS_REFUSED = 2'd1;
    localparam status_t STATUS_WAITING = 2'd2;

    typedef struct packed {
        slot_state_t state;
        thread_id_t  id;
        joiner_t     joiner;
        value_t      value;
    } slot_rec_t;

    typedef struct packed {
        logic      rd_en;
        slot_idx_t rd_addr;
        logic      wr_en;
        slot_idx_t wr_addr;
        slot_rec_t wr_data;
    } ram_req_t;

    function automatic slot_rec_t reset_rec(slot_idx_t idx);
        slot_rec_t r;
        r = '0;
        if (idx == '0)
        begin
            r.state = ST_RUNNING;
            r.id    = ID_BITS'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rrtt_slot_ram.sv =====
`timescale 1ns / 1ps
// rrtt_slot_ram: slot record memory, one read and one write port, registered read
// entries never written read as their reset record; depends on rrtt_pkg
module rrtt_slot_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  rrtt_pkg::ram_req_t  req,
    output rrtt_pkg::slot_rec_t rd_data
);
    import rrtt_pkg::*;

    slot_rec_t        mem [SLOTS];
    slot_rec_t        rd_raw_reg;
    logic [SLOTS-1:0] valid_reg;
    logic             rd_valid_reg;
    slot_idx_t        rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_raw_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
                rd_addr_reg  <= req.rd_addr;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : reset_rec(rd_addr_reg);

    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.rd_en && req.wr_en))
        else $error("slot ram read and write in the same cycle");

endmodule

// ===== rtl/core/round_robin_thread_table.sv =====
`timescale 1ns / 1ps
// round_robin_thread_table: thread slot table with a round-robin scheduler
// depends on rrtt_pkg and rrtt_slot_ram
//
// usage
//   req channel (req_valid / req_stall) carries one operation for the running
//   thread: opcode, target_id (join), exit_value (exit)
//   rsp channel (rsp_valid / rsp_stall) returns one result per operation:
//   status, created_id, joined_value, running_slot, running_id, switched
//   a transfer happens on a rising edge with valid high and stall low
//   one operation at a time: req_stall stays high from the request transfer until
//   the result is loaded; the table reads one slot per cycle from the slot ram
//   (current slot, then all SLOTS slots from the one after the current), then
//   writes back up to three slots, one per cycle, then registers the result
//   the next request is taken while a result still waits in the rsp register
//   a stalled result holds the last step; the block then waits before it
//   loads the next result
//   reset: slot 0 runs thread id 1, all other slots unused, next id 2;
//   no clearing pass, ready for a request right after reset
module round_robin_thread_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          opcode,
    input  logic [rrtt_pkg::ID_BITS-1:0]        target_id,
    input  logic [rrtt_pkg::VALUE_BITS-1:0]     exit_value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [1:0]                          status,
    output logic [rrtt_pkg::ID_BITS-1:0]        created_id,
    output logic [rrtt_pkg::VALUE_BITS-1:0]     joined_value,
    output logic [rrtt_pkg::SLOT_BITS-1:0]      running_slot,
    output logic [rrtt_pkg::ID_BITS-1:0]        running_id,
    output logic                                switched
);
    import rrtt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CUR  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WB0  = 3'd3;
    localparam logic [2:0] S_WB1  = 3'd4;
    localparam logic [2:0] S_WB2  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    function automatic slot_idx_t slot_inc(slot_idx_t idx);
        return (idx == SLOT_BITS'(SLOTS - 1)) ? '0 : idx + 1'b1;
    endfunction

    // control
    logic [2:0]  state_reg, state_next;
    slot_idx_t   current_reg, current_next;
    thread_id_t  next_id_reg, next_id_next;
    scan_cnt_t   scan_cnt_reg, scan_cnt_next;
    logic        free_found_reg, free_found_next;
    logic        tgt_found_reg, tgt_found_next;
    logic        pick_found_reg, pick_found_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // payload
    opcode_t     op_reg, op_next;
    thread_id_t  tid_reg, tid_next;
    value_t      val_reg, val_next;
    slot_rec_t   cur_rec_reg, cur_rec_next;
    slot_idx_t   rd_idx_reg, rd_idx_next;
    slot_idx_t   dat_idx_reg, dat_idx_next;
    slot_idx_t   free_idx_reg, free_idx_next;
    slot_idx_t   tgt_idx_reg, tgt_idx_next;
    slot_rec_t   tgt_rec_reg, tgt_rec_next;
    slot_idx_t   pick_idx_reg, pick_idx_next;
    slot_rec_t   pick_rec_reg, pick_rec_next;
    slot_rec_t   wake_rec_reg, wake_rec_next;
    status_t     status_reg, status_next;
    thread_id_t  created_id_reg, created_id_next;
    value_t      joined_value_reg, joined_value_next;
    slot_idx_t   running_slot_reg, running_slot_next;
    thread_id_t  running_id_reg, running_id_next;
    logic        switched_reg, switched_next;

    ram_req_t    ram_req;
    slot_rec_t   ram_rd;

    logic        wake_ok;
    slot_idx_t   wake_idx;
    joiner_t     self_link;
    slot_state_t eff_state;
    logic        create_ok, join_ok, join_reap, join_sleep, do_switch;
    slot_idx_t   new_cur;
    logic        wb_en;
    slot_idx_t   wb_idx;
    slot_rec_t   wb_base, wb_new;
    logic        rsp_load;

    rrtt_slot_ram u_slot_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    assign wake_ok   = (cur_rec_reg.joiner != '0);
    assign wake_idx  = SLOT_BITS'(cur_rec_reg.joiner - JOIN_BITS'(1));
    assign self_link = JOIN_BITS'(current_reg) + JOIN_BITS'(1);

    assign create_ok  = (op_reg == OP_CREATE) && free_found_reg;
    assign join_ok    = (op_reg == OP_JOIN) && tgt_found_reg && (tgt_idx_reg != current_reg)
                        && ((tgt_rec_reg.joiner == '0) || (tgt_rec_reg.joiner == self_link));
    assign join_reap  = join_ok && (tgt_rec_reg.state == ST_ZOMBIE);
    assign join_sleep = join_ok && !join_reap;
    assign do_switch  = pick_found_reg
                        && ((op_reg == OP_EXIT) || (op_reg == OP_YIELD) || join_sleep);
    assign new_cur    = do_switch ? pick_idx_reg : current_reg;

    // slot state as the scheduler sees it after this operation's own changes
    always_comb
    begin
        eff_state = ram_rd.state;
        case (op_reg)
            OP_EXIT:
            begin
                if (dat_idx_reg == current_reg)
                    eff_state = ST_ZOMBIE;
                else if (wake_ok && dat_idx_reg == wake_idx && ram_rd.state == ST_SLEEPING)
                    eff_state = ST_RUNNABLE;
            end
            OP_JOIN:
            begin
                if (dat_idx_reg == current_reg)
                    eff_state = ST_SLEEPING;
            end
            OP_YIELD:
            begin
                if (dat_idx_reg == current_reg && ram_rd.state == ST_RUNNING)
                    eff_state = ST_RUNNABLE;
            end
            default:
            begin
                eff_state = ram_rd.state;
            end
        endcase
    end

    // write-back slot selection
    always_comb
    begin
        wb_en   = 1'b0;
        wb_idx  = current_reg;
        wb_base = cur_rec_reg;
        case (state_reg)
            S_WB0:
            begin
                wb_en = 1'b1;
            end
            S_WB1:
            begin
                case (op_reg)
                    OP_CREATE:
                    begin
                        wb_en   = free_found_reg;
                        wb_idx  = free_idx_reg;
                        wb_base = '0;
                    end
                    OP_EXIT:
                    begin
                        wb_en   = wake_ok;
                        wb_idx  = wake_idx;
                        wb_base = wake_rec_reg;
                    end
                    OP_JOIN:
                    begin
                        wb_en   = tgt_found_reg;
                        wb_idx  = tgt_idx_reg;
                        wb_base = tgt_rec_reg;
                    end
                    default:
                    begin
                        wb_en = 1'b0;
                    end
                endcase
            end
            S_WB2:
            begin
                wb_en   = do_switch;
                wb_idx  = pick_idx_reg;
                wb_base = pick_rec_reg;
            end
            default:
            begin
                wb_en = 1'b0;
            end
        endcase
    end

    // new slot record from its old record; same answer for a slot written twice
    always_comb
    begin
        wb_new = wb_base;
        if (create_ok && wb_idx == free_idx_reg)
        begin
            wb_new.state  = ST_RUNNABLE;
            wb_new.id     = next_id_reg;
            wb_new.joiner = '0;
            wb_new.value  = '0;
        end
        if (op_reg == OP_EXIT)
        begin
            if (wb_idx == current_reg)
            begin
                wb_new.state = ST_ZOMBIE;
                wb_new.value = val_reg;
            end
            else if (wake_ok && wb_idx == wake_idx && wb_base.state == ST_SLEEPING)
            begin
                wb_new.state = ST_RUNNABLE;
            end
        end
        if (join_ok && wb_idx == tgt_idx_reg)
        begin
            if (join_reap)
                wb_new = '0;
            else
                wb_new.joiner = self_link;
        end
        if (join_sleep && wb_idx == current_reg)
        begin
            wb_new.state = ST_SLEEPING;
        end
        if (op_reg == OP_YIELD && wb_idx == current_reg && wb_base.state == ST_RUNNING)
        begin
            wb_new.state = ST_RUNNABLE;
        end
        if (do_switch && wb_idx == pick_idx_reg)
        begin
            wb_new.state = ST_RUNNING;
        end
    end

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next        = state_reg;
        current_next      = current_reg;
        next_id_next      = next_id_reg;
        scan_cnt_next     = scan_cnt_reg;
        free_found_next   = free_found_reg;
        tgt_found_next    = tgt_found_reg;
        pick_found_next   = pick_found_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        op_next           = op_reg;
        tid_next          = tid_reg;
        val_next          = val_reg;
        cur_rec_next      = cur_rec_reg;
        rd_idx_next       = rd_idx_reg;
        dat_idx_next      = dat_idx_reg;
        free_idx_next     = free_idx_reg;
        tgt_idx_next      = tgt_idx_reg;
        tgt_rec_next      = tgt_rec_reg;
        pick_idx_next     = pick_idx_reg;
        pick_rec_next     = pick_rec_reg;
        wake_rec_next     = wake_rec_reg;
        status_next       = status_reg;
        created_id_next   = created_id_reg;
        joined_value_next = joined_value_reg;
        running_slot_next = running_slot_reg;
        running_id_next   = running_id_reg;
        switched_next     = switched_reg;

        ram_req         = '0;
        ram_req.wr_en   = wb_en;
        ram_req.wr_addr = wb_idx;
        ram_req.wr_data = wb_new;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = opcode;
                    tid_next        = target_id;
                    val_next        = exit_value;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = current_reg;
                    rd_idx_next     = slot_inc(current_reg);
                    state_next      = S_CUR;
                end
            end
            S_CUR:
            begin
                cur_rec_next    = ram_rd;
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = rd_idx_reg;
                dat_idx_next    = rd_idx_reg;
                rd_idx_next     = slot_inc(rd_idx_reg);
                scan_cnt_next   = CNT_BITS'(1);
                free_found_next = 1'b0;
                tgt_found_next  = 1'b0;
                pick_found_next = 1'b0;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                if (eff_state == ST_RUNNABLE && !pick_found_reg)
                begin
                    pick_found_next = 1'b1;
                    pick_idx_next   = dat_idx_reg;
                    pick_rec_next   = ram_rd;
                end
                if (ram_rd.state == ST_UNUSED
                    && (!free_found_reg || dat_idx_reg < free_idx_reg))
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = dat_idx_reg;
                end
                if (ram_rd.state != ST_UNUSED && ram_rd.id == tid_reg
                    && (!tgt_found_reg || dat_idx_reg < tgt_idx_reg))
                begin
                    tgt_found_next = 1'b1;
                    tgt_idx_next   = dat_idx_reg;
                    tgt_rec_next   = ram_rd;
                end
                if (dat_idx_reg == wake_idx)
                begin
                    wake_rec_next = ram_rd;
                end
                if (scan_cnt_reg == CNT_BITS'(SLOTS))
                begin
                    state_next = S_WB0;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_idx_reg;
                    dat_idx_next    = rd_idx_reg;
                    rd_idx_next     = slot_inc(rd_idx_reg);
                    scan_cnt_next   = scan_cnt_reg + 1'b1;
                end
            end
            S_WB0:
            begin
                state_next = S_WB1;
            end
            S_WB1:
            begin
                state_next = S_WB2;
            end
            S_WB2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next    = 1'b1;
                    created_id_next   = create_ok ? next_id_reg : '0;
                    joined_value_next = join_reap ? tgt_rec_reg.value : '0;
                    running_slot_next = new_cur;
                    running_id_next   = do_switch ? pick_rec_reg.id : cur_rec_reg.id;
                    switched_next     = do_switch && (pick_idx_reg != current_reg);
                    current_next      = new_cur;
                    if ((op_reg == OP_CREATE && !free_found_reg)
                        || (op_reg == OP_JOIN && !join_ok))
                        status_next = STATUS_REFUSED;
                    else if (join_sleep)
                        status_next = STATUS_WAITING;
                    else
                        status_next = STATUS_DONE;
                    if (create_ok)
                        next_id_next = (&next_id_reg) ? ID_BITS'(1) : next_id_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            current_reg    <= '0;
            next_id_reg    <= ID_BITS'(2);
            scan_cnt_reg   <= '0;
            free_found_reg <= 1'b0;
            tgt_found_reg  <= 1'b0;
            pick_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            current_reg    <= current_next;
            next_id_reg    <= next_id_next;
            scan_cnt_reg   <= scan_cnt_next;
            free_found_reg <= free_found_next;
            tgt_found_reg  <= tgt_found_next;
            pick_found_reg <= pick_found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        tid_reg          <= tid_next;
        val_reg          <= val_next;
        cur_rec_reg      <= cur_rec_next;
        rd_idx_reg       <= rd_idx_next;
        dat_idx_reg      <= dat_idx_next;
        free_idx_reg     <= free_idx_next;
        tgt_idx_reg      <= tgt_idx_next;
        tgt_rec_reg      <= tgt_rec_next;
        pick_idx_reg     <= pick_idx_next;
        pick_rec_reg     <= pick_rec_next;
        wake_rec_reg     <= wake_rec_next;
        status_reg       <= status_next;
        created_id_reg   <= created_id_next;
        joined_value_reg <= joined_value_next;
        running_slot_reg <= running_slot_next;
        running_id_reg   <= running_id_next;
        switched_reg     <= switched_next;
    end

    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign created_id   = created_id_reg;
    assign joined_value = joined_value_reg;
    assign running_slot = running_slot_reg;
    assign running_id   = running_id_reg;
    assign switched     = switched_reg;

    a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CUR) |-> ##(SLOTS + 1) (state_reg == S_WB0))
        else $error("slot scan did not take one cycle per slot");

    a_create_not_current: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB1 && create_ok) |-> (free_idx_reg != current_reg))
        else $error("create picked the running slot");

    a_switch_has_id: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && switched_reg) |-> (running_id_reg != '0))
        else $error("switched to a slot without a thread id");

endmodule
